/* rtl/bsc_pkg.sv */
// ----------------------------------------------------------------------------
// bsc_pkg: shared types and codes for the banker's safety check block
// Request and result payloads, item kinds, status codes, register indexes
// and the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package bsc_pkg;

  localparam int KIND_W     = 3;
  localparam int PIDX_W     = 4;
  localparam int RIDX_W     = 3;
  localparam int AMT_W      = 16;
  localparam int STAT_W     = 3;
  localparam int SEQ_W      = 4;
  localparam int CFG_DATA_W = 5;

  localparam logic [KIND_W-1:0] KIND_LOAD_MAX  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD_HELD = 3'd1;
  localparam logic [KIND_W-1:0] KIND_LOAD_FREE = 3'd2;
  localparam logic [KIND_W-1:0] KIND_REQUEST   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CHECK     = 3'd4;

  localparam logic [STAT_W-1:0] STAT_SEQ       = 3'd0;
  localparam logic [STAT_W-1:0] STAT_SAFE      = 3'd1;
  localparam logic [STAT_W-1:0] STAT_UNSAFE    = 3'd2;
  localparam logic [STAT_W-1:0] STAT_GRANTED   = 3'd3;
  localparam logic [STAT_W-1:0] STAT_OVER_NEED = 3'd4;
  localparam logic [STAT_W-1:0] STAT_OVER_FREE = 3'd5;

  localparam logic CFG_ACTIVE_PROCESSES = 1'b0;
  localparam logic CFG_ACTIVE_RESOURCES = 1'b1;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [PIDX_W-1:0] process_index;
    logic [RIDX_W-1:0] resource_index;
    logic [AMT_W-1:0]  amount;
    logic              last_element;
  } request_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [SEQ_W-1:0]  seq_process;
    logic              last;
  } result_t;

  typedef struct packed {
    logic accept;
    logic free_wr;
    logic pend_wr;
    logic pend_clr;
    logic mem_rd;
    logic ld_wr_max;
    logic ld_wr_held;
    logic flag_clr;
    logic req_eval;
    logic work_init;
    logic tent;
    logic tent_hit;
    logic fit_set;
    logic chk_eval;
    logic add_eval;
    logic fin_set;
    logic cm_wr;
  } cmd_t;

  typedef struct packed {
    logic fit;
    logic over_need;
    logic over_free;
    logic done;
  } stat_t;

endpackage

/* rtl/bsc_dpath.sv */
// ----------------------------------------------------------------------------
// bsc_dpath: matrices, vectors and compare/add lanes
// Holds max, held and need memories, free and pending vectors, the work
// vector, finished flags and the safe sequence buffer.
// ----------------------------------------------------------------------------
module bsc_dpath #(
  parameter int MAX_P = 16,
  parameter int MAX_R = 8,
  parameter int UW    = 16,
  localparam int PW   = $clog2(MAX_P),
  localparam int RW   = (MAX_R > 1) ? $clog2(MAX_R) : 1,
  localparam int NRW  = $clog2(MAX_R + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  bsc_pkg::request_t request,
  input  bsc_pkg::cmd_t     cmd,
  input  logic [PW-1:0]     row,
  input  logic [RW-1:0]     col,
  input  logic [PW-1:0]     seq_idx,
  input  logic [NRW-1:0]    nr,
  output bsc_pkg::stat_t    stat,
  output logic [PW-1:0]     seq_out
);
  import bsc_pkg::*;

  localparam int AW    = PW + RW;
  localparam int DEPTH = 1 << AW;
  localparam int WW    = UW + 1;
  localparam int SW    = UW + 2;
  localparam logic [SW-1:0] WMAX = SW'((64'd1 << WW) - 64'd1);

  logic [UW-1:0] max_mem  [DEPTH];
  logic [UW-1:0] held_mem [DEPTH];
  logic [UW-1:0] need_mem [DEPTH];
  logic [UW-1:0] max_q, held_q, need_q;
  logic [UW-1:0] free_units [MAX_R];
  logic [UW-1:0] pend [MAX_R];
  logic [WW-1:0] work [MAX_R];
  logic [MAX_P-1:0] finished;
  logic [PW-1:0] seq_buf [MAX_P];
  logic [UW-1:0] amt_q;
  logic fit, over_need, over_free;

  logic [AW-1:0] addr;
  logic [RW-1:0] item_col;
  logic [UW-1:0] amt_in;
  logic [UW-1:0] ld_max, ld_held, ld_need;
  logic [UW-1:0] held_tent, need_tent, held_eff, need_eff, held_wr, need_wr;
  logic [SW-1:0] sum;
  logic [WW-1:0] sum_sat;

  assign addr     = {row, col};
  assign item_col = RW'(request.resource_index);
  assign amt_in   = UW'(request.amount);

  always_comb begin
    ld_max    = cmd.ld_wr_max ? amt_q : max_q;
    ld_held   = cmd.ld_wr_held ? amt_q : held_q;
    ld_need   = (ld_max >= ld_held) ? ld_max - ld_held : '0;
    held_tent = held_q + pend[col];
    need_tent = need_q - pend[col];
    held_eff  = cmd.tent_hit ? held_tent : held_q;
    need_eff  = cmd.tent_hit ? need_tent : need_q;
    held_wr   = cmd.cm_wr ? held_tent : amt_q;
    need_wr   = cmd.cm_wr ? need_tent : ld_need;
    sum       = SW'(work[col]) + SW'(held_eff);
    sum_sat   = (sum > WMAX) ? '1 : WW'(sum);
  end

  // memories: one address, registered read
  always_ff @(posedge clk) begin
    if (cmd.mem_rd) begin
      max_q  <= max_mem[addr];
      held_q <= held_mem[addr];
      need_q <= need_mem[addr];
    end
    if (cmd.ld_wr_max) max_mem[addr] <= amt_q;
    if (cmd.ld_wr_held || cmd.cm_wr) held_mem[addr] <= held_wr;
    if (cmd.ld_wr_max || cmd.ld_wr_held || cmd.cm_wr) need_mem[addr] <= need_wr;
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) amt_q <= amt_in;
    if (cmd.free_wr) free_units[item_col] <= amt_in;
    if (cmd.cm_wr) free_units[col] <= free_units[col] - pend[col];
    if (cmd.fin_set) seq_buf[seq_idx] <= row;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_R; i++) begin
        pend[i] <= '0;
        work[i] <= '0;
      end
      finished  <= '0;
      fit       <= 1'b0;
      over_need <= 1'b0;
      over_free <= 1'b0;
    end else begin
      if (cmd.pend_clr) begin
        for (int i = 0; i < MAX_R; i++) pend[i] <= '0;
      end else if (cmd.pend_wr) begin
        pend[item_col] <= amt_in;
      end
      if (cmd.flag_clr) begin
        over_need <= 1'b0;
        over_free <= 1'b0;
      end
      if (cmd.req_eval) begin
        if (pend[col] > need_q) over_need <= 1'b1;
        if (pend[col] > free_units[col]) over_free <= 1'b1;
      end
      if (cmd.work_init) begin
        finished <= '0;
        for (int i = 0; i < MAX_R; i++) begin
          if (i < int'(nr)) begin
            work[i] <= cmd.tent ? WW'(free_units[i] - pend[i]) : WW'(free_units[i]);
          end else begin
            work[i] <= '0;
          end
        end
      end
      if (cmd.fit_set) fit <= 1'b1;
      if (cmd.chk_eval && (WW'(need_eff) > work[col])) fit <= 1'b0;
      if (cmd.add_eval) work[col] <= sum_sat;
      if (cmd.fin_set) finished[row] <= 1'b1;
    end
  end

  assign stat.fit       = fit;
  assign stat.over_need = over_need;
  assign stat.over_free = over_free;
  assign stat.done      = finished[row];
  assign seq_out        = seq_buf[seq_idx];

endmodule

/* rtl/bsc_ctrl.sv */
// ----------------------------------------------------------------------------
// bsc_ctrl: sequencer for loads, request checks and the safety walk
// Decodes accepted requests, steps rows and columns, issues datapath
// commands and drives the registered result strobe.
// ----------------------------------------------------------------------------
module bsc_ctrl #(
  parameter int MAX_P = 16,
  parameter int MAX_R = 8,
  localparam int PW   = $clog2(MAX_P),
  localparam int RW   = (MAX_R > 1) ? $clog2(MAX_R) : 1,
  localparam int NPW  = $clog2(MAX_P + 1),
  localparam int NRW  = $clog2(MAX_R + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  bsc_pkg::request_t request,
  input  logic [NPW-1:0]    np,
  input  logic [NRW-1:0]    nr,
  input  bsc_pkg::stat_t    stat,
  input  logic [PW-1:0]     seq_out,
  output logic              busy,
  output bsc_pkg::cmd_t     cmd,
  output logic [PW-1:0]     row,
  output logic [RW-1:0]     col,
  output logic [PW-1:0]     seq_idx,
  output logic              result_valid,
  output bsc_pkg::result_t  result
);
  import bsc_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_LD_RD   = 4'd1;
  localparam logic [3:0] S_LD_WR   = 4'd2;
  localparam logic [3:0] S_RQ_RD   = 4'd3;
  localparam logic [3:0] S_RQ_EV   = 4'd4;
  localparam logic [3:0] S_RQ_DEC  = 4'd5;
  localparam logic [3:0] S_SF_INIT = 4'd6;
  localparam logic [3:0] S_SF_NEXT = 4'd7;
  localparam logic [3:0] S_SF_CRD  = 4'd8;
  localparam logic [3:0] S_SF_CEV  = 4'd9;
  localparam logic [3:0] S_SF_CDEC = 4'd10;
  localparam logic [3:0] S_SF_ARD  = 4'd11;
  localparam logic [3:0] S_SF_AEV  = 4'd12;
  localparam logic [3:0] S_CM_RD   = 4'd13;
  localparam logic [3:0] S_CM_WR   = 4'd14;
  localparam logic [3:0] S_EMIT    = 4'd15;

  logic [3:0]     state, state_next;
  logic [PW-1:0]  proc, proc_next;
  logic [PW-1:0]  req_row, req_row_next;
  logic [RW-1:0]  col_c, col_next;
  logic [NPW-1:0] n_c, n_next;
  logic [NPW-1:0] e_c, e_next;
  logic           moved, moved_next;
  logic           mode_req, mode_req_next;
  logic           ld_max, ld_max_next;
  logic           res_valid_next;
  result_t        res_next;

  logic           pok, rok, last_col, last_proc, adv, adv_fin, moved_v;
  logic [NPW-1:0] n_v;
  logic           sf_state;

  assign pok       = int'(request.process_index) < int'(np);
  assign rok       = int'(request.resource_index) < int'(nr);
  assign last_col  = (NRW'(col_c) + NRW'(1)) == nr;
  assign last_proc = (NPW'(proc) + NPW'(1)) == np;
  assign sf_state  = (state == S_SF_NEXT) || (state == S_SF_CRD) || (state == S_SF_CEV) ||
                     (state == S_SF_CDEC) || (state == S_SF_ARD) || (state == S_SF_AEV);
  assign busy      = state != S_IDLE;
  assign row       = sf_state ? proc : req_row;
  assign col       = col_c;
  assign seq_idx   = (state == S_EMIT) ? PW'(e_c) : PW'(n_c);

  always_comb begin
    state_next     = state;
    proc_next      = proc;
    req_row_next   = req_row;
    col_next       = col_c;
    n_next         = n_c;
    e_next         = e_c;
    moved_next     = moved;
    mode_req_next  = mode_req;
    ld_max_next    = ld_max;
    res_valid_next = 1'b0;
    res_next       = result;
    cmd            = '0;
    cmd.tent       = mode_req;
    cmd.tent_hit   = mode_req && (proc == req_row);
    adv            = 1'b0;
    adv_fin        = 1'b0;
    moved_v        = moved;
    n_v            = n_c;

    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          case (request.kind)
            KIND_LOAD_MAX, KIND_LOAD_HELD: begin
              if (pok && rok) begin
                req_row_next = PW'(request.process_index);
                col_next     = RW'(request.resource_index);
                ld_max_next  = request.kind == KIND_LOAD_MAX;
                state_next   = S_LD_RD;
              end
            end
            KIND_LOAD_FREE: begin
              cmd.free_wr = rok;
            end
            KIND_REQUEST: begin
              cmd.pend_wr = rok;
              if (request.last_element) begin
                if (!pok) begin
                  cmd.pend_clr = 1'b1;
                end else begin
                  req_row_next = PW'(request.process_index);
                  col_next     = '0;
                  cmd.flag_clr = 1'b1;
                  state_next   = S_RQ_RD;
                end
              end
            end
            KIND_CHECK: begin
              mode_req_next = 1'b0;
              state_next    = S_SF_INIT;
            end
            default: ;
          endcase
        end
      end
      S_LD_RD: begin
        cmd.mem_rd = 1'b1;
        state_next = S_LD_WR;
      end
      S_LD_WR: begin
        cmd.ld_wr_max  = ld_max;
        cmd.ld_wr_held = !ld_max;
        state_next     = S_IDLE;
      end
      S_RQ_RD: begin
        cmd.mem_rd = 1'b1;
        state_next = S_RQ_EV;
      end
      S_RQ_EV: begin
        cmd.req_eval = 1'b1;
        if (last_col) begin
          state_next = S_RQ_DEC;
        end else begin
          col_next   = col_c + RW'(1);
          state_next = S_RQ_RD;
        end
      end
      S_RQ_DEC: begin
        if (stat.over_need || stat.over_free) begin
          cmd.pend_clr   = 1'b1;
          res_valid_next = 1'b1;
          res_next       = '{stat.over_need ? STAT_OVER_NEED : STAT_OVER_FREE, '0, 1'b1};
          state_next     = S_IDLE;
        end else begin
          mode_req_next = 1'b1;
          state_next    = S_SF_INIT;
        end
      end
      S_SF_INIT: begin
        cmd.work_init = 1'b1;
        proc_next     = '0;
        n_next        = '0;
        moved_next    = 1'b0;
        state_next    = S_SF_NEXT;
      end
      S_SF_NEXT: begin
        if (stat.done) begin
          adv = 1'b1;
        end else begin
          col_next    = '0;
          cmd.fit_set = 1'b1;
          state_next  = S_SF_CRD;
        end
      end
      S_SF_CRD: begin
        cmd.mem_rd = 1'b1;
        state_next = S_SF_CEV;
      end
      S_SF_CEV: begin
        cmd.chk_eval = 1'b1;
        if (last_col) begin
          state_next = S_SF_CDEC;
        end else begin
          col_next   = col_c + RW'(1);
          state_next = S_SF_CRD;
        end
      end
      S_SF_CDEC: begin
        if (stat.fit) begin
          col_next   = '0;
          state_next = S_SF_ARD;
        end else begin
          adv = 1'b1;
        end
      end
      S_SF_ARD: begin
        cmd.mem_rd = 1'b1;
        state_next = S_SF_AEV;
      end
      S_SF_AEV: begin
        cmd.add_eval = 1'b1;
        if (last_col) begin
          cmd.fin_set = 1'b1;
          adv         = 1'b1;
          adv_fin     = 1'b1;
        end else begin
          col_next   = col_c + RW'(1);
          state_next = S_SF_ARD;
        end
      end
      S_CM_RD: begin
        cmd.mem_rd = 1'b1;
        state_next = S_CM_WR;
      end
      S_CM_WR: begin
        cmd.cm_wr = 1'b1;
        if (last_col) begin
          cmd.pend_clr = 1'b1;
          e_next       = '0;
          state_next   = S_EMIT;
        end else begin
          col_next   = col_c + RW'(1);
          state_next = S_CM_RD;
        end
      end
      S_EMIT: begin
        res_valid_next = 1'b1;
        if (e_c == n_c) begin
          res_next   = '{mode_req ? STAT_GRANTED : STAT_SAFE, '0, 1'b1};
          state_next = S_IDLE;
        end else begin
          res_next = '{STAT_SEQ, SEQ_W'(seq_out), 1'b0};
          e_next   = e_c + NPW'(1);
        end
      end
      default: state_next = S_IDLE;
    endcase

    // advance to the next process; close the pass on the last one
    if (adv) begin
      moved_v    = moved || adv_fin;
      n_v        = n_c + NPW'(adv_fin);
      n_next     = n_v;
      moved_next = moved_v;
      if (last_proc) begin
        if (n_v == np) begin
          col_next   = '0;
          e_next     = '0;
          state_next = mode_req ? S_CM_RD : S_EMIT;
        end else if (!moved_v) begin
          cmd.pend_clr   = mode_req;
          res_valid_next = 1'b1;
          res_next       = '{STAT_UNSAFE, '0, 1'b1};
          state_next     = S_IDLE;
        end else begin
          proc_next  = '0;
          moved_next = 1'b0;
          state_next = S_SF_NEXT;
        end
      end else begin
        proc_next  = proc + PW'(1);
        state_next = S_SF_NEXT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      mode_req     <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= res_valid_next;
      mode_req     <= mode_req_next;
    end
  end

  always_ff @(posedge clk) begin
    proc    <= proc_next;
    req_row <= req_row_next;
    col_c   <= col_next;
    n_c     <= n_next;
    e_c     <= e_next;
    moved   <= moved_next;
    ld_max  <= ld_max_next;
    result  <= res_next;
  end

endmodule

/* rtl/bankers_safety_check.sv */
// ----------------------------------------------------------------------------
// bankers_safety_check: banker's algorithm deadlock-avoidance engine
// Keeps claim, held and need matrices and grants resource requests only
// when a safe completion order still exists.
// ----------------------------------------------------------------------------
// Usage:
//   Drive a request on `request` and raise start; it is taken at a clock
//   edge where start is high and busy is low. Loads of max or held then
//   read and write the addressed cell; free loads and non-final request
//   elements finish at acceptance. A final request element is compared
//   against need and free units column by column and, if within both,
//   runs the safety walk. The walk visits each unfinished process, tests
//   it against work, adds its held units if it fits, and repeats passes
//   until all finish or a pass admits nobody (up to np passes). A granted
//   request then writes back its row and the free units.
//   Results leave on `result`, one per cycle, each marked by result_valid
//   for exactly one cycle: any safe sequence first, then a verdict with
//   last set. The receiver cannot stall; every strobe is a delivered result.
//   Configuration writes on cfg_valid/cfg_ready (always ready) set the
//   active process and resource counts; write them only while idle.
//   Synchronous reset returns to idle, clears pending request and work
//   state and sets counts to full; matrices and free units stay undefined
//   until loaded.
// ----------------------------------------------------------------------------
module bankers_safety_check #(
  parameter int MAX_PROCESSES = 16,
  parameter int MAX_RESOURCES = 8,
  parameter int UNIT_WIDTH    = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  bsc_pkg::request_t               request,
  output logic                            result_valid,
  output bsc_pkg::result_t                result,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic                            cfg_index,
  input  logic [bsc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import bsc_pkg::*;

  localparam int PW  = $clog2(MAX_PROCESSES);
  localparam int RW  = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
  localparam int NPW = $clog2(MAX_PROCESSES + 1);
  localparam int NRW = $clog2(MAX_RESOURCES + 1);

  logic [4:0]     active_processes;
  logic [3:0]     active_resources;
  logic [NPW-1:0] np;
  logic [NRW-1:0] nr;
  cmd_t           cmd;
  stat_t          stat;
  logic [PW-1:0]  row, seq_idx, seq_out;
  logic [RW-1:0]  col;

  assign cfg_ready = 1'b1;

  // hold the register values; clamp them to the supported range on use
  always_ff @(posedge clk) begin
    if (rst) begin
      active_processes <= 5'd16;
      active_resources <= 4'd8;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ACTIVE_PROCESSES: active_processes <= cfg_data;
        CFG_ACTIVE_RESOURCES: active_resources <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  assign np = (int'(active_processes) > MAX_PROCESSES) ? NPW'(MAX_PROCESSES) :
              (active_processes == '0) ? NPW'(1) : NPW'(active_processes);
  assign nr = (int'(active_resources) > MAX_RESOURCES) ? NRW'(MAX_RESOURCES) :
              (active_resources == '0) ? NRW'(1) : NRW'(active_resources);

  bsc_ctrl #(
    .MAX_P (MAX_PROCESSES),
    .MAX_R (MAX_RESOURCES)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .request      (request),
    .np           (np),
    .nr           (nr),
    .stat         (stat),
    .seq_out      (seq_out),
    .busy         (busy),
    .cmd          (cmd),
    .row          (row),
    .col          (col),
    .seq_idx      (seq_idx),
    .result_valid (result_valid),
    .result       (result)
  );

  bsc_dpath #(
    .MAX_P (MAX_PROCESSES),
    .MAX_R (MAX_RESOURCES),
    .UW    (UNIT_WIDTH)
  ) u_dpath (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .cmd     (cmd),
    .row     (row),
    .col     (col),
    .seq_idx (seq_idx),
    .nr      (nr),
    .stat    (stat),
    .seq_out (seq_out)
  );

`ifndef SYNTHESIS
  // a result only follows a cycle of work
  a_result_after_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy))
    else $error("result without preceding work");

  // the verdict closes the run: the block is idle again
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.last) |-> !busy)
    else $error("busy after final result");

  // an accepted check always starts the safety walk
  a_check_starts: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && request.kind == KIND_CHECK) |=> busy)
    else $error("check request not started");
`endif

endmodule
